// ===== src/exdq_pkg.sv =====
// shared types and constants for the expiring deque
// no dependencies; imported by the controller, datapath, top level and checker
`default_nettype none

package exdq_pkg;

   localparam int DATA_BITS = 32;
   localparam int LIFE_BITS = 16;
   localparam int CMD_BITS  = 3;
   localparam int STAT_BITS = 2;

   localparam logic [CMD_BITS-1:0] CMD_PUSH_FRONT = 3'd0;
   localparam logic [CMD_BITS-1:0] CMD_PUSH_BACK  = 3'd1;
   localparam logic [CMD_BITS-1:0] CMD_POP_FRONT  = 3'd2;
   localparam logic [CMD_BITS-1:0] CMD_POP_BACK   = 3'd3;
   localparam logic [CMD_BITS-1:0] CMD_TICK       = 3'd4;
   localparam logic [CMD_BITS-1:0] CMD_LIST_FWD   = 3'd5;
   localparam logic [CMD_BITS-1:0] CMD_LIST_BWD   = 3'd6;

   localparam logic [STAT_BITS-1:0] STAT_OK    = 2'd0;
   localparam logic [STAT_BITS-1:0] STAT_FULL  = 2'd1;
   localparam logic [STAT_BITS-1:0] STAT_EMPTY = 2'd2;

   localparam logic [LIFE_BITS-1:0] LIFETIME_RESET = 16'd10;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DECODE,
      ST_SIMPLE,
      ST_POP_RD,
      ST_POP_RES,
      ST_SCAN_RD,
      ST_SCAN_EV,
      ST_LIST_CHK,
      ST_EMIT_RD,
      ST_EMIT_RES
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic latch_req;
      logic clear_idx;
      logic rd_pop;
      logic rd_scan;
      logic rd_emit;
      logic simple_done;
      logic pop_done;
      logic scan_ev;
      logic emit_done;
   } ctrl_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic [CMD_BITS-1:0] cmd;
      logic                empty;
      logic                scan_end;
      logic                emit_last;
      logic                out_free;
   } dp_status_type;

endpackage

`default_nettype wire

// ===== src/exdq_ctrl.sv =====
// sequencing state machine for the expiring deque
// depends on exdq_pkg; drives the datapath through ctrl_cmd_type
`default_nettype none

module exdq_ctrl import exdq_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output logic               req_stall,
   input  dp_status_type      status,
   output ctrl_cmd_type       cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_DECODE;
         end
         ST_DECODE: begin
            if (status.cmd inside {CMD_POP_FRONT, CMD_POP_BACK}) begin
               state_in = status.empty ? ST_SIMPLE : ST_POP_RD;
            end else if (status.cmd inside {CMD_LIST_FWD, CMD_LIST_BWD}) begin
               state_in = status.empty ? ST_LIST_CHK : ST_SCAN_RD;
            end else begin
               state_in = ST_SIMPLE;
            end
         end
         ST_SIMPLE: begin
            if (status.out_free) state_in = ST_IDLE;
         end
         ST_POP_RD: begin
            state_in = ST_POP_RES;
         end
         ST_POP_RES: begin
            if (status.out_free) state_in = ST_IDLE;
         end
         ST_SCAN_RD: begin
            state_in = ST_SCAN_EV;
         end
         ST_SCAN_EV: begin
            state_in = status.scan_end ? ST_LIST_CHK : ST_SCAN_RD;
         end
         ST_LIST_CHK: begin
            state_in = status.empty ? ST_SIMPLE : ST_EMIT_RD;
         end
         ST_EMIT_RD: begin
            state_in = ST_EMIT_RES;
         end
         ST_EMIT_RES: begin
            if (status.out_free) state_in = status.emit_last ? ST_IDLE : ST_EMIT_RD;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            req_stall     = 1'b0;
            cmd.latch_req = req_valid;
         end
         ST_DECODE:   cmd.clear_idx   = 1'b1;
         ST_SIMPLE:   cmd.simple_done = status.out_free;
         ST_POP_RD:   cmd.rd_pop      = 1'b1;
         ST_POP_RES:  cmd.pop_done    = status.out_free;
         ST_SCAN_RD:  cmd.rd_scan     = 1'b1;
         ST_SCAN_EV:  cmd.scan_ev     = 1'b1;
         ST_LIST_CHK: cmd.clear_idx   = 1'b1;
         ST_EMIT_RD:  cmd.rd_emit     = 1'b1;
         ST_EMIT_RES: cmd.emit_done   = status.out_free;
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

`default_nettype wire

// ===== src/exdq_dp.sv =====
// datapath of the expiring deque: ring storage, pointers, tick counter,
// lifetime register and the result register; depends on exdq_pkg
`default_nettype none

module exdq_dp import exdq_pkg::*; #(
   parameter int DEPTH     = 16,
   parameter int TIME_BITS = 32
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  ctrl_cmd_type                       cmd,
   output dp_status_type                      status,
   input  wire logic [CMD_BITS-1:0]           req_cmd,
   input  wire logic signed [DATA_BITS-1:0]   req_data_in,
   input  wire logic                          csr_wr_en,
   input  wire logic [LIFE_BITS-1:0]          csr_wr_data,
   input  wire logic                          rsp_stall,
   output logic                               rsp_valid,
   output logic signed [DATA_BITS-1:0]        rsp_data_out,
   output logic                               rsp_item_valid,
   output logic [STAT_BITS-1:0]               rsp_status,
   output logic [$clog2(DEPTH+1)-1:0]         rsp_entry_count,
   output logic                               rsp_last
);

   localparam int AW   = $clog2(DEPTH);
   localparam int CW   = $clog2(DEPTH + 1);
   localparam int CMPW = (TIME_BITS > LIFE_BITS) ? TIME_BITS : LIFE_BITS;
   localparam logic [AW:0]   DEPTH_EXT = (AW + 1)'(DEPTH);
   localparam logic [CW-1:0] DEPTH_CNT = CW'(DEPTH);
   localparam logic [AW-1:0] LAST_POS  = AW'(DEPTH - 1);

   function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] base,
                                              input logic [AW-1:0] offs);
      logic [AW:0] sum;
      sum = {1'b0, base} + {1'b0, offs};
      if (sum >= DEPTH_EXT) sum = sum - DEPTH_EXT;
      return sum[AW-1:0];
   endfunction

   logic [CMD_BITS-1:0]         cmd_ff;
   logic [DATA_BITS-1:0]        data_ff;
   logic [AW-1:0]               head_ff, head_in;
   logic [CW-1:0]               count_ff, count_in;
   logic [CW-1:0]               scan_ff, scan_in;
   logic [CW-1:0]               keep_ff, keep_in;
   logic [CW-1:0]               emit_ff, emit_in;
   logic [TIME_BITS-1:0]        now_ff, now_in;
   logic [LIFE_BITS-1:0]        lifetime_ff, lifetime_in;

   logic [DATA_BITS-1:0]        value_mem [DEPTH];
   logic [TIME_BITS-1:0]        stamp_mem [DEPTH];
   logic [DATA_BITS-1:0]        rvalue_ff;
   logic [TIME_BITS-1:0]        rstamp_ff;

   logic                        rsp_valid_ff, rsp_valid_in;
   logic [DATA_BITS-1:0]        rsp_data_ff, rsp_data_in;
   logic                        rsp_item_ff, rsp_item_in;
   logic [STAT_BITS-1:0]        rsp_status_ff, rsp_status_in;
   logic [CW-1:0]               rsp_count_ff, rsp_count_in;
   logic                        rsp_last_ff, rsp_last_in;
   logic                        rsp_load;

   logic                        full, empty, is_push, is_front, fwd, survive;
   logic [CW-1:0]               cnt_m1, scan_p1, keep_p1, emit_p1, back_off;
   logic [AW-1:0]               head_dec, head_inc;
   logic [AW-1:0]               addr_tail, addr_back, addr_scan, addr_keep, addr_emit;
   logic [TIME_BITS-1:0]        age;
   logic                        rd_en, we;
   logic [AW-1:0]               raddr, waddr;
   logic [DATA_BITS-1:0]        wvalue;
   logic [TIME_BITS-1:0]        wstamp;

   assign full     = (count_ff == DEPTH_CNT);
   assign empty    = (count_ff == '0);
   assign is_push  = (cmd_ff inside {CMD_PUSH_FRONT, CMD_PUSH_BACK});
   assign is_front = (cmd_ff inside {CMD_PUSH_FRONT, CMD_POP_FRONT});
   assign fwd      = (cmd_ff == CMD_LIST_FWD);

   assign cnt_m1   = count_ff - CW'(1);
   assign scan_p1  = scan_ff + CW'(1);
   assign keep_p1  = keep_ff + CW'(1);
   assign emit_p1  = emit_ff + CW'(1);
   assign back_off = cnt_m1 - emit_ff;

   assign head_dec  = (head_ff == '0) ? LAST_POS : head_ff - AW'(1);
   assign head_inc  = wrap_add(head_ff, AW'(1));
   // count only truncates here when full, and then no push is written
   assign addr_tail = wrap_add(head_ff, count_ff[AW-1:0]);
   assign addr_back = wrap_add(head_ff, cnt_m1[AW-1:0]);
   assign addr_scan = wrap_add(head_ff, scan_ff[AW-1:0]);
   assign addr_keep = wrap_add(head_ff, keep_ff[AW-1:0]);
   assign addr_emit = wrap_add(head_ff, fwd ? emit_ff[AW-1:0] : back_off[AW-1:0]);

   // wrapping age against lifetime, an age equal to lifetime survives
   assign age     = now_ff - rstamp_ff;
   assign survive = (CMPW'(age) <= CMPW'(lifetime_ff));

   always_comb begin
      rd_en = cmd.rd_pop | cmd.rd_scan | cmd.rd_emit;
      if (cmd.rd_pop) begin
         raddr = is_front ? head_ff : addr_back;
      end else if (cmd.rd_scan) begin
         raddr = addr_scan;
      end else begin
         raddr = addr_emit;
      end
   end

   always_comb begin
      we     = 1'b0;
      waddr  = addr_keep;
      wvalue = rvalue_ff;
      wstamp = rstamp_ff;
      if (cmd.simple_done && is_push && !full) begin
         we     = 1'b1;
         waddr  = (cmd_ff == CMD_PUSH_FRONT) ? head_dec : addr_tail;
         wvalue = data_ff;
         wstamp = now_ff;
      end else if (cmd.scan_ev && survive) begin
         we = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (we) begin
         value_mem[waddr] <= wvalue;
         stamp_mem[waddr] <= wstamp;
      end
      if (rd_en) begin
         rvalue_ff <= value_mem[raddr];
         rstamp_ff <= stamp_mem[raddr];
      end
   end

   always_comb begin
      head_in     = head_ff;
      count_in    = count_ff;
      scan_in     = scan_ff;
      keep_in     = keep_ff;
      emit_in     = emit_ff;
      now_in      = now_ff;
      lifetime_in = csr_wr_en ? csr_wr_data : lifetime_ff;
      if (cmd.clear_idx) begin
         scan_in = '0;
         keep_in = '0;
         emit_in = '0;
      end
      if (cmd.simple_done) begin
         if (is_push && !full) begin
            count_in = count_ff + CW'(1);
            if (cmd_ff == CMD_PUSH_FRONT) head_in = head_dec;
         end
         if (cmd_ff == CMD_TICK) now_in = now_ff + TIME_BITS'(1);
      end
      if (cmd.pop_done) begin
         count_in = cnt_m1;
         if (is_front) head_in = head_inc;
      end
      if (cmd.scan_ev) begin
         scan_in = scan_p1;
         if (survive) keep_in = keep_p1;
         // the compacted entries stay packed from the head
         if (scan_p1 == count_ff) count_in = survive ? keep_p1 : keep_ff;
      end
      if (cmd.emit_done) emit_in = emit_p1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff     <= '0;
         count_ff    <= '0;
         scan_ff     <= '0;
         keep_ff     <= '0;
         emit_ff     <= '0;
         now_ff      <= '0;
         lifetime_ff <= LIFETIME_RESET;
      end else begin
         head_ff     <= head_in;
         count_ff    <= count_in;
         scan_ff     <= scan_in;
         keep_ff     <= keep_in;
         emit_ff     <= emit_in;
         now_ff      <= now_in;
         lifetime_ff <= lifetime_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.latch_req) begin
         cmd_ff  <= req_cmd;
         data_ff <= req_data_in;
      end
   end

   // result beat register
   always_comb begin
      rsp_load      = cmd.simple_done | cmd.pop_done | cmd.emit_done;
      rsp_data_in   = rvalue_ff;
      rsp_item_in   = 1'b1;
      rsp_status_in = STAT_OK;
      rsp_count_in  = count_ff;
      rsp_last_in   = 1'b1;
      if (cmd.simple_done) begin
         rsp_data_in = '0;
         rsp_item_in = 1'b0;
         if (is_push && full) begin
            rsp_status_in = STAT_FULL;
         end else if (is_push) begin
            rsp_count_in = count_ff + CW'(1);
         end else if (cmd_ff inside {CMD_POP_FRONT, CMD_POP_BACK}) begin
            rsp_status_in = STAT_EMPTY;
         end
      end else if (cmd.pop_done) begin
         rsp_count_in = cnt_m1;
      end else begin
         rsp_last_in = (emit_p1 == count_ff);
      end
      rsp_valid_in = rsp_load | (rsp_valid_ff & rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_data_ff   <= rsp_data_in;
         rsp_item_ff   <= rsp_item_in;
         rsp_status_ff <= rsp_status_in;
         rsp_count_ff  <= rsp_count_in;
         rsp_last_ff   <= rsp_last_in;
      end
   end

   assign status.cmd       = cmd_ff;
   assign status.empty     = empty;
   assign status.scan_end  = (scan_p1 == count_ff);
   assign status.emit_last = (emit_p1 == count_ff);
   assign status.out_free  = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_data_out    = rsp_data_ff;
   assign rsp_item_valid  = rsp_item_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_entry_count = rsp_count_ff;
   assign rsp_last        = rsp_last_ff;

endmodule

`default_nettype wire

// ===== src/expiring_deque_top.sv =====
// top level of the expiring deque: controller plus datapath
// depends on exdq_pkg, exdq_ctrl and exdq_dp
//
// A bounded double-ended queue of signed 32-bit values, each stamped with the
// tick count at push time, held in a ring buffer with one write and one
// registered read port. One command is taken at a time. Push, tick and a pop
// on an empty deque go from decode straight to the result beat; a pop of an
// entry first does one read of the ring. A list first runs the expiry sweep,
// which reads and re-packs each held entry through the single read port, then
// reads and presents each survivor in turn; an empty list gives one invalid
// beat. Result stalls can lengthen every command.
// The input is stalled until the last result beat of a command is loaded.
// No clearing pass is needed after reset.
`default_nettype none

module expiring_deque_top import exdq_pkg::*; #(
   parameter int DEPTH     = 16,
   parameter int TIME_BITS = 32
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic [CMD_BITS-1:0]           req_cmd,
   input  wire logic signed [DATA_BITS-1:0]   req_data_in,
   input  wire logic                          csr_wr_en,
   input  wire logic [LIFE_BITS-1:0]          csr_wr_data,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic signed [DATA_BITS-1:0]        rsp_data_out,
   output logic                               rsp_item_valid,
   output logic [STAT_BITS-1:0]               rsp_status,
   output logic [$clog2(DEPTH+1)-1:0]         rsp_entry_count,
   output logic                               rsp_last
);

   ctrl_cmd_type  ctrl_cmd;
   dp_status_type dp_status;

   exdq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (dp_status),
      .cmd       (ctrl_cmd)
   );

   exdq_dp #(
      .DEPTH     (DEPTH),
      .TIME_BITS (TIME_BITS)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (ctrl_cmd),
      .status          (dp_status),
      .req_cmd         (req_cmd),
      .req_data_in     (req_data_in),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .rsp_stall       (rsp_stall),
      .rsp_valid       (rsp_valid),
      .rsp_data_out    (rsp_data_out),
      .rsp_item_valid  (rsp_item_valid),
      .rsp_status      (rsp_status),
      .rsp_entry_count (rsp_entry_count),
      .rsp_last        (rsp_last)
   );

endmodule

`default_nettype wire

// ===== src/exdq_checker.sv =====
// port-level checks for expiring_deque_top, attached by the bind below
// depends on exdq_pkg
`default_nettype none

module exdq_checker import exdq_pkg::*; #(
   parameter int DEPTH = 16
) (
   input wire logic                          clock,
   input wire logic                          reset,
   input wire logic                          req_stall,
   input wire logic                          rsp_valid,
   input wire logic                          rsp_stall,
   input wire logic signed [DATA_BITS-1:0]   rsp_data_out,
   input wire logic                          rsp_item_valid,
   input wire logic [STAT_BITS-1:0]          rsp_status,
   input wire logic [$clog2(DEPTH+1)-1:0]    rsp_entry_count,
   input wire logic                          rsp_last
);

   localparam int CW = $clog2(DEPTH + 1);

   // a stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data_out) &&
      $stable(rsp_item_valid) && $stable(rsp_status) &&
      $stable(rsp_entry_count) && $stable(rsp_last))
      else $error("result beat changed while stalled");

   // only listed entries can be followed by more beats
   a_noitem_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_item_valid |-> rsp_last)
      else $error("non-entry beat not marked last");

   a_err_beat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != STAT_OK |-> !rsp_item_valid && rsp_last)
      else $error("error beat carries an entry or is not last");

   // while a list is still being emitted no new command may enter
   a_list_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> req_stall)
      else $error("command accepted in the middle of a list");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_entry_count <= CW'(DEPTH))
      else $error("entry count beyond depth");

endmodule

bind expiring_deque_top exdq_checker #(.DEPTH(DEPTH)) u_exdq_checker (
   .clock           (clock),
   .reset           (reset),
   .req_stall       (req_stall),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_data_out    (rsp_data_out),
   .rsp_item_valid  (rsp_item_valid),
   .rsp_status      (rsp_status),
   .rsp_entry_count (rsp_entry_count),
   .rsp_last        (rsp_last)
);

`default_nettype wire

// ===== tb/exdq_scoreboard_pkg.sv =====
// result predictor and checker for the expiring deque testbench
// depends on exdq_pkg; used by tb_top
package exdq_scoreboard_pkg;
   import exdq_pkg::*;

   localparam int DEQUE_DEPTH = 16;
   localparam int STAMP_BITS  = 32;
   localparam int COUNT_BITS  = $clog2(DEQUE_DEPTH + 1);
   localparam logic [CMD_BITS-1:0] CMD_UNUSED = 3'd7;
   localparam int REPORT_LIMIT = 10;

   typedef struct {
      logic signed [DATA_BITS-1:0] data_out;
      logic                        item_valid;
      logic [STAT_BITS-1:0]        status;
      logic [COUNT_BITS-1:0]       entry_count;
      logic                        last;
   } deque_beat_type;

   class deque_scoreboard;
      logic signed [DATA_BITS-1:0] values [DEQUE_DEPTH];
      logic [STAMP_BITS-1:0]       stamps [DEQUE_DEPTH];
      int unsigned                 held;
      logic [STAMP_BITS-1:0]       ticks_now;
      logic [LIFE_BITS-1:0]        lifetime;
      deque_beat_type              awaited [$];
      int unsigned mismatches, beats_checked, commands_seen;
      int unsigned full_drops, empty_pops, expired_entries;

      function new();
         held = 0;
         ticks_now = '0;
         lifetime = LIFETIME_RESET;
         mismatches = 0;
         beats_checked = 0;
         commands_seen = 0;
         full_drops = 0;
         empty_pops = 0;
         expired_entries = 0;
      endfunction

      function void add_beat(logic signed [DATA_BITS-1:0] data, logic valid,
                             logic [STAT_BITS-1:0] status, logic last);
         deque_beat_type beat;
         beat.data_out    = data;
         beat.item_valid  = valid;
         beat.status      = status;
         beat.entry_count = COUNT_BITS'(held);
         beat.last        = last;
         awaited.push_back(beat);
      endfunction

      // works out the result beats of one accepted command
      function void predict_command(logic [CMD_BITS-1:0] cmd,
                                    logic signed [DATA_BITS-1:0] data);
         int unsigned                 keep;
         int unsigned                 pos;
         logic signed [DATA_BITS-1:0] taken;
         logic [STAMP_BITS-1:0]       age;
         commands_seen++;
         case (cmd)
            CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
               if (held >= DEQUE_DEPTH) begin
                  full_drops++;
                  add_beat('0, 1'b0, STAT_FULL, 1'b1);
               end else begin
                  if (cmd == CMD_PUSH_FRONT) begin
                     for (int i = held; i > 0; i--) begin
                        values[i] = values[i-1];
                        stamps[i] = stamps[i-1];
                     end
                     values[0] = data;
                     stamps[0] = ticks_now;
                  end else begin
                     values[held] = data;
                     stamps[held] = ticks_now;
                  end
                  held++;
                  add_beat('0, 1'b0, STAT_OK, 1'b1);
               end
            end
            CMD_POP_FRONT, CMD_POP_BACK: begin
               if (held == 0) begin
                  empty_pops++;
                  add_beat('0, 1'b0, STAT_EMPTY, 1'b1);
               end else begin
                  if (cmd == CMD_POP_FRONT) begin
                     taken = values[0];
                     for (int i = 1; i < held; i++) begin
                        values[i-1] = values[i];
                        stamps[i-1] = stamps[i];
                     end
                  end else begin
                     taken = values[held-1];
                  end
                  held--;
                  add_beat(taken, 1'b1, STAT_OK, 1'b1);
               end
            end
            CMD_TICK: begin
               ticks_now = ticks_now + 1'b1;
               add_beat('0, 1'b0, STAT_OK, 1'b1);
            end
            CMD_LIST_FWD, CMD_LIST_BWD: begin
               // age equal to the lifetime still survives
               keep = 0;
               for (int i = 0; i < held; i++) begin
                  age = ticks_now - stamps[i];
                  if (age <= STAMP_BITS'(lifetime)) begin
                     values[keep] = values[i];
                     stamps[keep] = stamps[i];
                     keep++;
                  end
               end
               expired_entries += held - keep;
               held = keep;
               if (held == 0) begin
                  add_beat('0, 1'b0, STAT_OK, 1'b1);
               end else begin
                  for (int i = 0; i < held; i++) begin
                     pos = (cmd == CMD_LIST_FWD) ? i : held - 1 - i;
                     add_beat(values[pos], 1'b1, STAT_OK, (i + 1 == held));
                  end
               end
            end
            default: begin
               add_beat('0, 1'b0, STAT_OK, 1'b1);
            end
         endcase
      endfunction

      function void check_result(deque_beat_type got);
         deque_beat_type want;
         beats_checked++;
         if (awaited.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
               $display("unexpected beat: data %0d valid %0b status %0d count %0d last %0b",
                        got.data_out, got.item_valid, got.status, got.entry_count, got.last);
            return;
         end
         want = awaited.pop_front();
         if (got.data_out !== want.data_out || got.item_valid !== want.item_valid ||
             got.status !== want.status || got.entry_count !== want.entry_count ||
             got.last !== want.last) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT) begin
               $display("beat %0d expected: data %0d valid %0b status %0d count %0d last %0b",
                        beats_checked, want.data_out, want.item_valid, want.status,
                        want.entry_count, want.last);
               $display("beat %0d actual:   data %0d valid %0b status %0d count %0d last %0b",
                        beats_checked, got.data_out, got.item_valid, got.status,
                        got.entry_count, got.last);
            end
         end
      endfunction
   endclass

endpackage

// ===== tb/tb_top.sv =====
// top of the expiring deque testbench: clock, reset, stimulus, result sink, watchdog
// depends on exdq_pkg, exdq_scoreboard_pkg and expiring_deque_top
module tb_top;
   import exdq_pkg::*;
   import exdq_scoreboard_pkg::*;

   localparam int IDLE_LIMIT = 2000;
   localparam int SETTLE     = 8;
   localparam int TAIL       = 80;
   localparam int PHASE_ITEMS = 88;

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        req_valid = 1'b0;
   logic                        req_stall;
   logic [CMD_BITS-1:0]         req_cmd = '0;
   logic signed [DATA_BITS-1:0] req_data_in = '0;
   logic                        csr_wr_en = 1'b0;
   logic [LIFE_BITS-1:0]        csr_wr_data = '0;
   logic                        rsp_valid;
   logic                        rsp_stall = 1'b0;
   logic signed [DATA_BITS-1:0] rsp_data_out;
   logic                        rsp_item_valid;
   logic [STAT_BITS-1:0]        rsp_status;
   logic [COUNT_BITS-1:0]       rsp_entry_count;
   logic                        rsp_last;

   deque_scoreboard board;
   deque_beat_type  seen_beat;
   bit              no_idle = 1'b0;
   int              rsp_hold = 0;
   int              quiet_cycles = 0;
   int              last_life = 0;

   expiring_deque_top #(.DEPTH(DEQUE_DEPTH), .TIME_BITS(STAMP_BITS)) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_cmd(req_cmd),
      .req_data_in(req_data_in),
      .csr_wr_en(csr_wr_en),
      .csr_wr_data(csr_wr_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data_out(rsp_data_out),
      .rsp_item_valid(rsp_item_valid),
      .rsp_status(rsp_status),
      .rsp_entry_count(rsp_entry_count),
      .rsp_last(rsp_last)
   );

   always #2 clock = ~clock;

   function automatic int draw_wait();
      return no_idle ? 0 : $urandom_range(0, 9);
   endfunction

   function automatic logic signed [DATA_BITS-1:0] random_value();
      case ($urandom_range(0, 7))
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2: return 32'h0000_0000;
         3: return 32'hffff_ffff;
         default: return $urandom;
      endcase
   endfunction

   task automatic send_command(input logic [CMD_BITS-1:0] cmd,
                               input logic signed [DATA_BITS-1:0] data);
      int gap;
      gap = draw_wait();
      // valid only drops when a gap follows, so it is never lowered and raised in one step
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_cmd     <= cmd;
      req_data_in <= data;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      board.predict_command(cmd, data);
   endtask

   task automatic wait_idle(input int settle);
      req_valid <= 1'b0;
      while (board.awaited.size() != 0) @(posedge clock);
      repeat (settle) @(posedge clock);
   endtask

   task automatic write_lifetime(input logic [LIFE_BITS-1:0] life);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= life;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      board.lifetime = life;
   endtask

   // runs of well-formed work: fills, drains, aging followed by a list, and some noise
   task automatic run_phase(input int budget);
      int sent;
      int kind;
      int len;
      sent = 0;
      while (sent < budget) begin
         no_idle = ($urandom_range(0, 3) == 0);
         kind = $urandom_range(0, 9);
         if (kind < 3) begin
            len = $urandom_range(4, 20);
            repeat (len)
               send_command($urandom_range(0, 1) ? CMD_PUSH_BACK : CMD_PUSH_FRONT,
                            random_value());
         end else if (kind < 5) begin
            len = $urandom_range(2, 18);
            repeat (len)
               send_command($urandom_range(0, 1) ? CMD_POP_BACK : CMD_POP_FRONT,
                            random_value());
         end else if (kind < 8) begin
            len = $urandom_range(0, 4);
            repeat (len) send_command(CMD_TICK, random_value());
            send_command($urandom_range(0, 1) ? CMD_LIST_BWD : CMD_LIST_FWD,
                         random_value());
            len++;
         end else begin
            len = $urandom_range(1, 6);
            repeat (len) send_command(CMD_BITS'($urandom_range(0, 7)), random_value());
         end
         sent += len;
      end
      no_idle = 1'b0;
   endtask

   // result sink: after each beat the stall is held for a freshly drawn count
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         rsp_hold = 0;
      end else if (rsp_valid && !rsp_stall) begin
         seen_beat.data_out    = rsp_data_out;
         seen_beat.item_valid  = rsp_item_valid;
         seen_beat.status      = rsp_status;
         seen_beat.entry_count = rsp_entry_count;
         seen_beat.last        = rsp_last;
         board.check_result(seen_beat);
         rsp_hold = draw_wait();
         rsp_stall <= (rsp_hold != 0);
      end else if (rsp_hold != 0) begin
         rsp_hold = rsp_hold - 1;
         rsp_stall <= (rsp_hold != 0);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= IDLE_LIMIT) begin
         $display("no beat accepted for %0d cycles", IDLE_LIMIT);
         $display("expiring_deque_top: mismatch");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      board = new();
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed: empty cases, extreme values, order of both ends, expiry edge
      write_lifetime(16'd1);
      send_command(CMD_POP_FRONT, 32'h0);
      send_command(CMD_POP_BACK, 32'h0);
      send_command(CMD_LIST_FWD, 32'h0);
      send_command(CMD_LIST_BWD, 32'h0);
      send_command(CMD_UNUSED, 32'h5a5a_a5a5);
      send_command(CMD_PUSH_BACK, 32'h7fff_ffff);
      send_command(CMD_PUSH_FRONT, 32'h8000_0000);
      send_command(CMD_PUSH_BACK, 32'hffff_ffff);
      send_command(CMD_PUSH_FRONT, 32'h0);
      send_command(CMD_POP_FRONT, 32'h0);
      send_command(CMD_POP_BACK, 32'h0);
      send_command(CMD_LIST_FWD, 32'h0);
      send_command(CMD_LIST_BWD, 32'h0);
      send_command(CMD_TICK, 32'h0);
      send_command(CMD_PUSH_BACK, 32'd5);
      send_command(CMD_LIST_FWD, 32'h0);
      send_command(CMD_TICK, 32'h0);
      send_command(CMD_LIST_BWD, 32'h0);
      send_command(CMD_TICK, 32'h0);
      send_command(CMD_LIST_FWD, 32'h0);
      send_command(CMD_POP_FRONT, 32'h0);
      wait_idle(SETTLE);

      // fill past capacity so the full case and a maximal listing are reached early
      write_lifetime(LIFETIME_RESET);
      repeat (18) send_command(CMD_PUSH_BACK, random_value());
      send_command(CMD_LIST_BWD, 32'h0);
      run_phase(PHASE_ITEMS - 19);
      wait_idle(SETTLE);

      write_lifetime(16'd0);
      run_phase(PHASE_ITEMS);
      wait_idle(SETTLE);

      write_lifetime(16'hffff);
      run_phase(PHASE_ITEMS);
      wait_idle(SETTLE);

      write_lifetime(16'd3);
      run_phase(PHASE_ITEMS);
      wait_idle(SETTLE);

      last_life = $urandom_range(1, 20);
      write_lifetime(LIFE_BITS'(last_life));
      run_phase(PHASE_ITEMS);
      wait_idle(TAIL);

      $display("covered %0d commands and %0d result beats, lifetimes 1, 10, 0, 65535, 3, %0d",
               board.commands_seen, board.beats_checked, last_life);
      $display("%0d pushes dropped when full, %0d pops on empty, %0d entries aged out",
               board.full_drops, board.empty_pops, board.expired_entries);
      if (board.mismatches == 0 && board.awaited.size() == 0) begin
         $display("expiring_deque_top: match");
      end else begin
         $display("%0d mismatches, %0d beats still expected", board.mismatches,
                  board.awaited.size());
         $display("expiring_deque_top: mismatch");
      end
      $finish;
   end

endmodule

// ===== expiring_deque_top.f =====
src/exdq_pkg.sv
src/exdq_ctrl.sv
src/exdq_dp.sv
src/expiring_deque_top.sv
src/exdq_checker.sv
tb/exdq_scoreboard_pkg.sv
tb/tb_top.sv
